@@ sv/tmhq_pkg.sv @@
// ---------------------------------------------------------------------------
// tmhq_pkg
// Shared types, constants and codes of the timer min-heap queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tmhq_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int TIME_BITS    = 48;
  localparam int WAIT_CLAMP   = 1073741824;
  localparam int HANDLE_COUNT = 32;
  localparam int HANDLE_W     = 5;
  localparam int SLOT_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CHILD_W      = SLOT_W + 2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NOT_QUEUED = 3'd1,
    STS_ALREADY    = 3'd2,
    STS_FULL       = 3'd3,
    STS_NONE_DUE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REM_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE,
    S_EXP_RD,
    S_EXP_CHK,
    S_Q_CMP,
    S_RESP
  } state_t;

  typedef struct packed {
    cmd_t                  command;
    logic [HANDLE_W-1:0]   timer_handle;
    logic [TIME_BITS-1:0]  expiry_time;
    logic [TIME_BITS-1:0]  now_time;
    logic signed [31:0]    wait_limit;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   out_handle;
    logic                  became_earliest;
    logic signed [31:0]    wait_ms;
    logic                  last_result;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   handle;
    logic [TIME_BITS-1:0]  expiry;
  } slot_t;

  typedef struct packed {
    logic                  q_we;
    logic                  q_val;
    logic [HANDLE_W-1:0]   q_handle;
    logic                  p_we;
    logic [HANDLE_W-1:0]   p_handle;
    logic [SLOT_W-1:0]     p_slot;
  } pos_cmd_t;

endpackage

`default_nettype wire

@@ sv/tmhq_heap_ram.sv @@
// ---------------------------------------------------------------------------
// tmhq_heap_ram
// Heap slot memory: handle and expiry per slot, one write and one
// registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tmhq_heap_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tmhq_pkg::SLOT_W-1:0] waddr,
  input  wire tmhq_pkg::slot_t             wdata,
  input  wire logic                        re,
  input  wire logic [tmhq_pkg::SLOT_W-1:0] raddr,
  output tmhq_pkg::slot_t                  rdata
);

  tmhq_pkg::slot_t mem [tmhq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/tmhq_pos_map.sv @@
// ---------------------------------------------------------------------------
// tmhq_pos_map
// Per-handle queued flag and heap slot, with a lookup for one handle.
// ---------------------------------------------------------------------------
`default_nettype none

module tmhq_pos_map (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tmhq_pkg::pos_cmd_t                  cmd,
  input  wire logic [tmhq_pkg::HANDLE_W-1:0]       lk_handle,
  output logic                                     lk_queued,
  output logic [tmhq_pkg::SLOT_W-1:0]              lk_pos,
  output logic [tmhq_pkg::HANDLE_COUNT-1:0]        queued_bits
);

  logic [tmhq_pkg::HANDLE_COUNT-1:0] queued;
  logic [tmhq_pkg::SLOT_W-1:0]       pos [tmhq_pkg::HANDLE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      queued <= '0;
    end else if (cmd.q_we) begin
      queued[cmd.q_handle] <= cmd.q_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_we) begin
      pos[cmd.p_handle] <= cmd.p_slot;
    end
  end

  assign lk_queued   = queued[lk_handle];
  assign lk_pos      = pos[lk_handle];
  assign queued_bits = queued;

endmodule

`default_nettype wire

@@ sv/timer_min_heap_queue.sv @@
// ---------------------------------------------------------------------------
// timer_min_heap_queue
// Timer queue kept as an indexed binary min-heap on expiry time.
// ---------------------------------------------------------------------------
// One command is worked at a time. Heap slots sit in a one-port-read memory,
// so every heap level costs a read, a compare and a write; sift-down reads
// the left and then the right child before its compare. A new command is
// taken once the previous one has handed its last result to the output
// register.
`default_nettype none

module timer_min_heap_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire tmhq_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output tmhq_pkg::rsp_t      rsp
);

  localparam int SW = tmhq_pkg::SLOT_W;
  localparam int CW = tmhq_pkg::CNT_W;
  localparam int KW = tmhq_pkg::CHILD_W;
  localparam int TB = tmhq_pkg::TIME_BITS;

  tmhq_pkg::state_t state, state_next;

  tmhq_pkg::cmd_t                 op;
  logic [tmhq_pkg::HANDLE_W-1:0]  hreq;
  logic [TB-1:0]                  exp_r, now_r;
  logic signed [31:0]             lim_r;
  logic [CW-1:0]                  cnt, cnt_next;
  logic [SW-1:0]                  idx, idx_next;
  tmhq_pkg::slot_t                cur, cur_next, lft, lft_next;
  logic                           r_ok, r_ok_next;
  logic                           first_up, first_up_next;
  logic                           first_exp, first_exp_next;
  logic [tmhq_pkg::HANDLE_W-1:0]  pend_h, pend_h_next;
  tmhq_pkg::rsp_t                 resp, resp_next;

  logic                           ram_we, ram_re;
  logic [SW-1:0]                  ram_waddr, ram_raddr;
  tmhq_pkg::slot_t                ram_wdata, rd;
  tmhq_pkg::pos_cmd_t             pcmd;
  logic                           lk_queued;
  logic [SW-1:0]                  lk_pos;
  logic [tmhq_pkg::HANDLE_COUNT-1:0] queued_bits;

  logic                           emit;
  tmhq_pkg::rsp_t                 emit_item;

  tmhq_heap_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  tmhq_pos_map u_pos (
    .clk         (clk),
    .rst         (rst),
    .cmd         (pcmd),
    .lk_handle   (hreq),
    .lk_queued   (lk_queued),
    .lk_pos      (lk_pos),
    .queued_bits (queued_bits)
  );

  // shared decisions
  logic [SW-1:0] par_idx, last_slot;
  logic [KW-1:0] l_idx, r_idx, cnt_ext;
  logic          l_ok, r_in, up_less, sel_l, sel_r, due, out_free;
  logic [TB-1:0] best_e, diff;
  logic [63:0]   diff64;
  logic [31:0]   clamped, wait_q;

  assign par_idx   = (idx - SW'(1)) >> 1;
  assign last_slot = SW'(cnt - CW'(1));
  assign l_idx     = {1'b0, idx, 1'b1};
  assign r_idx     = l_idx + KW'(1);
  assign cnt_ext   = KW'(cnt);
  assign l_ok      = l_idx < cnt_ext;
  assign r_in      = r_idx < cnt_ext;
  assign up_less   = cur.expiry < rd.expiry;
  assign sel_l     = lft.expiry < cur.expiry;
  assign best_e    = sel_l ? lft.expiry : cur.expiry;
  assign sel_r     = r_ok && (rd.expiry < best_e);
  assign due       = rd.expiry <= now_r;
  assign out_free  = !rsp_valid || !rsp_stall;

  // query answer
  assign diff    = rd.expiry - now_r;
  assign diff64  = 64'(diff);
  assign clamped = (diff64 >= 64'(tmhq_pkg::WAIT_CLAMP)) ? 32'(tmhq_pkg::WAIT_CLAMP)
                                                          : 32'(diff64) + 32'd1;
  always_comb begin
    if (due) begin
      wait_q = '0;
    end else if (lim_r[31] || clamped <= 32'(lim_r)) begin
      wait_q = clamped;
    end else begin
      wait_q = 32'(lim_r);
    end
  end

  assign req_stall = (state != tmhq_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmhq_pkg::S_IDLE: begin
        if (req_valid) state_next = tmhq_pkg::S_DECODE;
      end
      tmhq_pkg::S_DECODE: begin
        state_next = tmhq_pkg::S_RESP;
        case (op)
          tmhq_pkg::CMD_ADD: begin
            if (!lk_queued && cnt < CW'(tmhq_pkg::QUEUE_DEPTH))
              state_next = tmhq_pkg::S_UP_RD;
          end
          tmhq_pkg::CMD_CANCEL: begin
            if (lk_queued && CW'(lk_pos) < cnt && lk_pos != last_slot)
              state_next = tmhq_pkg::S_REM_LD;
          end
          tmhq_pkg::CMD_EXPIRE: begin
            if (cnt != '0) state_next = tmhq_pkg::S_EXP_CHK;
          end
          default: begin
            if (cnt != '0) state_next = tmhq_pkg::S_Q_CMP;
          end
        endcase
      end
      tmhq_pkg::S_REM_LD: begin
        state_next = (idx != '0) ? tmhq_pkg::S_UP_RD : tmhq_pkg::S_DN_RDL;
      end
      tmhq_pkg::S_UP_RD: begin
        state_next = (idx == '0) ? tmhq_pkg::S_DONE : tmhq_pkg::S_UP_CMP;
      end
      tmhq_pkg::S_UP_CMP: begin
        if (up_less) state_next = tmhq_pkg::S_UP_RD;
        else if (first_up) state_next = tmhq_pkg::S_DN_RDL;
        else state_next = tmhq_pkg::S_DONE;
      end
      tmhq_pkg::S_DN_RDL: begin
        state_next = l_ok ? tmhq_pkg::S_DN_RDR : tmhq_pkg::S_DONE;
      end
      tmhq_pkg::S_DN_RDR: state_next = tmhq_pkg::S_DN_CMP;
      tmhq_pkg::S_DN_CMP: begin
        state_next = (sel_r || sel_l) ? tmhq_pkg::S_DN_RDL : tmhq_pkg::S_DONE;
      end
      tmhq_pkg::S_DONE: begin
        state_next = (op == tmhq_pkg::CMD_EXPIRE) ? tmhq_pkg::S_EXP_RD : tmhq_pkg::S_RESP;
      end
      tmhq_pkg::S_EXP_RD: begin
        state_next = (cnt != '0) ? tmhq_pkg::S_EXP_CHK : tmhq_pkg::S_RESP;
      end
      tmhq_pkg::S_EXP_CHK: begin
        if (!due) state_next = tmhq_pkg::S_RESP;
        else if (first_exp || out_free)
          state_next = (cnt == CW'(1)) ? tmhq_pkg::S_EXP_RD : tmhq_pkg::S_REM_LD;
      end
      tmhq_pkg::S_Q_CMP: state_next = tmhq_pkg::S_RESP;
      tmhq_pkg::S_RESP: begin
        if (out_free) state_next = tmhq_pkg::S_IDLE;
      end
      default: state_next = tmhq_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cnt_next       = cnt;
    idx_next       = idx;
    cur_next       = cur;
    lft_next       = lft;
    r_ok_next      = r_ok;
    first_up_next  = first_up;
    first_exp_next = first_exp;
    pend_h_next    = pend_h;
    resp_next      = resp;
    ram_we         = 1'b0;
    ram_waddr      = idx;
    ram_wdata      = cur;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    pcmd           = '0;
    emit           = 1'b0;
    emit_item      = resp;
    unique case (state)
      tmhq_pkg::S_IDLE: ;
      tmhq_pkg::S_DECODE: begin
        resp_next = '{status: tmhq_pkg::STS_OK, out_handle: hreq, became_earliest: 1'b0,
                      wait_ms: '0, last_result: 1'b1};
        case (op)
          tmhq_pkg::CMD_ADD: begin
            if (lk_queued) begin
              resp_next.status = tmhq_pkg::STS_ALREADY;
            end else if (cnt >= CW'(tmhq_pkg::QUEUE_DEPTH)) begin
              resp_next.status = tmhq_pkg::STS_FULL;
            end else begin
              cur_next      = '{handle: hreq, expiry: exp_r};
              idx_next      = SW'(cnt);
              cnt_next      = cnt + CW'(1);
              first_up_next = 1'b0;
              pcmd.q_we     = 1'b1;
              pcmd.q_val    = 1'b1;
              pcmd.q_handle = hreq;
            end
          end
          tmhq_pkg::CMD_CANCEL: begin
            if (!lk_queued || CW'(lk_pos) >= cnt) begin
              resp_next.status = tmhq_pkg::STS_NOT_QUEUED;
            end else begin
              idx_next      = lk_pos;
              cnt_next      = cnt - CW'(1);
              pcmd.q_we     = 1'b1;
              pcmd.q_handle = hreq;
              ram_re        = 1'b1;
              ram_raddr     = last_slot;
            end
          end
          tmhq_pkg::CMD_EXPIRE: begin
            first_exp_next = 1'b1;
            resp_next.out_handle = '0;
            resp_next.status     = tmhq_pkg::STS_NONE_DUE;
            ram_re = (cnt != '0);
          end
          default: begin
            resp_next.out_handle = '0;
            resp_next.wait_ms    = lim_r;
            ram_re = (cnt != '0);
          end
        endcase
      end
      tmhq_pkg::S_REM_LD: begin
        // last entry fills the hole, may go up or down
        cur_next      = rd;
        first_up_next = (idx != '0);
      end
      tmhq_pkg::S_UP_RD: begin
        if (idx == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = par_idx;
        end
      end
      tmhq_pkg::S_UP_CMP: begin
        if (up_less) begin
          ram_we        = 1'b1;
          ram_wdata     = rd;
          idx_next      = par_idx;
          first_up_next = 1'b0;
        end else if (first_up) begin
          first_up_next = 1'b0;
        end else begin
          ram_we = 1'b1;
        end
      end
      tmhq_pkg::S_DN_RDL: begin
        if (l_ok) begin
          ram_re    = 1'b1;
          ram_raddr = SW'(l_idx);
        end else begin
          ram_we = 1'b1;
        end
      end
      tmhq_pkg::S_DN_RDR: begin
        lft_next  = rd;
        r_ok_next = r_in;
        ram_re    = r_in;
        ram_raddr = SW'(r_idx);
      end
      tmhq_pkg::S_DN_CMP: begin
        ram_we = 1'b1;
        if (sel_r) begin
          ram_wdata = rd;
          idx_next  = SW'(r_idx);
        end else if (sel_l) begin
          ram_wdata = lft;
          idx_next  = SW'(l_idx);
        end
      end
      tmhq_pkg::S_DONE: begin
        resp_next = '{status: tmhq_pkg::STS_OK, out_handle: hreq,
                      became_earliest: (op == tmhq_pkg::CMD_ADD) && (idx == '0),
                      wait_ms: '0, last_result: 1'b1};
      end
      tmhq_pkg::S_EXP_RD: begin
        ram_re = (cnt != '0);
        resp_next = '{status: tmhq_pkg::STS_OK, out_handle: pend_h, became_earliest: 1'b0,
                      wait_ms: '0, last_result: 1'b1};
      end
      tmhq_pkg::S_EXP_CHK: begin
        if (!due) begin
          if (!first_exp) begin
            resp_next = '{status: tmhq_pkg::STS_OK, out_handle: pend_h,
                          became_earliest: 1'b0, wait_ms: '0, last_result: 1'b1};
          end
        end else if (first_exp || out_free) begin
          // previous pop is known not to be the last one
          emit      = !first_exp;
          emit_item = '{status: tmhq_pkg::STS_OK, out_handle: pend_h,
                        became_earliest: 1'b0, wait_ms: '0, last_result: 1'b0};
          pend_h_next    = rd.handle;
          first_exp_next = 1'b0;
          idx_next       = '0;
          cnt_next       = cnt - CW'(1);
          pcmd.q_we      = 1'b1;
          pcmd.q_handle  = rd.handle;
          ram_re         = (cnt != CW'(1));
          ram_raddr      = last_slot;
        end
      end
      tmhq_pkg::S_Q_CMP: begin
        resp_next.wait_ms = wait_q;
      end
      tmhq_pkg::S_RESP: begin
        emit = out_free;
      end
      default: ;
    endcase
    pcmd.p_we     = ram_we;
    pcmd.p_handle = ram_wdata.handle;
    pcmd.p_slot   = ram_waddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tmhq_pkg::S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tmhq_pkg::S_IDLE && req_valid) begin
      op    <= req.command;
      hreq  <= req.timer_handle;
      exp_r <= req.expiry_time;
      now_r <= req.now_time;
      lim_r <= req.wait_limit;
    end
    if (emit) begin
      rsp <= emit_item;
    end
    idx       <= idx_next;
    cur       <= cur_next;
    lft       <= lft_next;
    r_ok      <= r_ok_next;
    first_up  <= first_up_next;
    first_exp <= first_exp_next;
    pend_h    <= pend_h_next;
    resp      <= resp_next;
  end

  // queued flags and heap fill stay in step
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(queued_bits) == int'(cnt))
    else $error("queued flags disagree with heap count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(tmhq_pkg::QUEUE_DEPTH))
    else $error("heap count above depth");

  a_earliest_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.became_earliest |-> rsp.status == tmhq_pkg::STS_OK)
    else $error("became_earliest on a failed transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("new transaction taken while one is in progress");

endmodule

`default_nettype wire
